// ===== rtl/core/best_fit_partition_allocator_assert.svh =====
// assertion macros used by the allocator checker
`ifndef BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_PARTITION_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BFPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/bfpa_pkg.sv =====
// shared types and constants of the best-fit partition allocator
package bfpa_pkg;

   localparam int FREE_ENTRIES = 16;
   localparam int USED_ENTRIES = 16;
   localparam int ADDR_BITS = 19;
   localparam int SIZE_BITS = ADDR_BITS + 1;
   localparam int ID_BITS = 16;
   localparam int CSR_IDX_BITS = 2;

   localparam int FREE_IDX_BITS = $clog2(FREE_ENTRIES);
   localparam int USED_IDX_BITS = $clog2(USED_ENTRIES);
   localparam int IDX_BITS = (FREE_IDX_BITS > USED_IDX_BITS) ? FREE_IDX_BITS : USED_IDX_BITS;

   localparam logic [ADDR_BITS-1:0] MEM_TOP_RESET = ADDR_BITS'(524287);
   localparam logic [ADDR_BITS-1:0] RESERVED_RESET = ADDR_BITS'(131072);

   localparam logic [CSR_IDX_BITS-1:0] CSR_MEMORY_TOP = CSR_IDX_BITS'(0);
   localparam logic [CSR_IDX_BITS-1:0] CSR_RESERVED_SIZE = CSR_IDX_BITS'(1);

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   typedef enum logic [2:0] {
      ST_BEST_FIT = 3'd0,
      ST_COMPACTED = 3'd1,
      ST_INSUFFICIENT = 3'd2,
      ST_RELEASED = 3'd3,
      ST_ID_NOT_FOUND = 3'd4,
      ST_TABLE_FULL = 3'd5
   } status_type;

   typedef struct packed {
      logic op;
      logic [ID_BITS-1:0] job_id;
      logic [SIZE_BITS-1:0] request_size;
   } req_type;

   typedef struct packed {
      status_type status;
      logic [ID_BITS-1:0] job_id_out;
      logic [ADDR_BITS-1:0] base_address;
      logic [SIZE_BITS-1:0] region_size;
      logic [SIZE_BITS-1:0] free_total;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_IDLE,
      DP_START,
      DP_SLOT,
      DP_FIT,
      DP_CPICK,
      DP_CMOVE,
      DP_CFREE,
      DP_ALLOC,
      DP_FIND,
      DP_MERGE,
      DP_REL,
      DP_REJ_SIZE,
      DP_REJ_FULL,
      DP_REJ_ID,
      DP_LOAD
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic last;
      logic init_busy;
      logic alloc_reject;
      logic slot_found;
      logic fit_found;
      logic pick_found;
      logic owner_found;
      logic merge_ok;
      logic rsp_full;
   } dp_status_type;

endpackage

// ===== rtl/core/best_fit_partition_allocator.sv =====
// top level of the best-fit partition allocator
//
//   channel  ports                         direction  transaction
//   req      req_valid/req_ready/req_data  in         allocate or release request
//   rsp      rsp_valid/rsp_ready/rsp_data  out        one result per request
//   csr      csr_we/csr_index/csr_wdata    in         memory_top, reserved_size
//
// allocate: the result follows one-entry-per-cycle scans of the used and the free table;
// a compaction adds one selection pass over the used table per region in use plus a
// final empty pass. release: scans of the used and the free table. an insufficient
// request is rejected before any table scan.
// after reset, and in the cycle of a register write, both tables are rebuilt; req_ready
// stays low for one cycle after reset. a result waiting on rsp_ready does not block
// the next request until that request's own result is ready.
module best_fit_partition_allocator
   import bfpa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data,
   input  logic csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0] csr_wdata
);

   dp_cmd_type cmd;
   dp_status_type st;

   bfpa_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_op(req_data.op),
      .req_ready(req_ready),
      .rsp_ready(rsp_ready),
      .st(st),
      .cmd(cmd)
   );

   bfpa_datapath u_dp (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .st(st),
      .req_data(req_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

endmodule

// ===== rtl/core/bfpa_ctrl.sv =====
// sequencing state machine of the allocator
module bfpa_ctrl
   import bfpa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_op,
   output logic req_ready,
   input  logic rsp_ready,
   input  dp_status_type st,
   output dp_cmd_type cmd
);

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_CHECK  = 13'b0000000000010,
      S_SLOT   = 13'b0000000000100,
      S_FIT    = 13'b0000000001000,
      S_DECIDE = 13'b0000000010000,
      S_CPICK  = 13'b0000000100000,
      S_CMOVE  = 13'b0000001000000,
      S_CFREE  = 13'b0000010000000,
      S_ALLOC  = 13'b0000100000000,
      S_FIND   = 13'b0001000000000,
      S_MERGE  = 13'b0010000000000,
      S_RDEC   = 13'b0100000000000,
      S_DONE   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd.op = DP_IDLE;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = !st.init_busy;
            if (req_valid && !st.init_busy) begin
               cmd.op = DP_START;
               state_in = (req_op == OP_RELEASE) ? S_FIND : S_CHECK;
            end
         end
         S_CHECK: begin
            if (st.alloc_reject) begin
               cmd.op = DP_REJ_SIZE;
               state_in = S_DONE;
            end else begin
               state_in = S_SLOT;
            end
         end
         S_SLOT: begin
            cmd.op = DP_SLOT;
            if (st.last) state_in = S_FIT;
         end
         S_FIT: begin
            cmd.op = DP_FIT;
            if (st.last) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!st.slot_found) begin
               cmd.op = DP_REJ_FULL;
               state_in = S_DONE;
            end else if (st.fit_found) begin
               state_in = S_ALLOC;
            end else begin
               state_in = S_CPICK;
            end
         end
         S_CPICK: begin
            cmd.op = DP_CPICK;
            if (st.last) state_in = S_CMOVE;
         end
         S_CMOVE: begin
            cmd.op = DP_CMOVE;
            state_in = st.pick_found ? S_CPICK : S_CFREE;
         end
         S_CFREE: begin
            cmd.op = DP_CFREE;
            state_in = S_ALLOC;
         end
         S_ALLOC: begin
            cmd.op = DP_ALLOC;
            state_in = S_DONE;
         end
         S_FIND: begin
            cmd.op = DP_FIND;
            if (st.last) state_in = S_MERGE;
         end
         S_MERGE: begin
            cmd.op = DP_MERGE;
            if (st.last) state_in = S_RDEC;
         end
         S_RDEC: begin
            if (!st.owner_found) cmd.op = DP_REJ_ID;
            else if (!st.merge_ok) cmd.op = DP_REJ_FULL;
            else cmd.op = DP_REL;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!st.rsp_full || rsp_ready) begin
               cmd.op = DP_LOAD;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

endmodule

// ===== rtl/core/bfpa_datapath.sv =====
// tables, scan registers and result register of the allocator
module bfpa_datapath
   import bfpa_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  dp_cmd_type cmd,
   output dp_status_type st,
   input  req_type req_data,
   input  logic csr_we,
   input  logic [CSR_IDX_BITS-1:0] csr_index,
   input  logic [ADDR_BITS-1:0] csr_wdata,
   output logic rsp_valid,
   input  logic rsp_ready,
   output rsp_type rsp_data
);

   localparam int A = ADDR_BITS;
   localparam int S = SIZE_BITS;

   logic [A-1:0] top_ff, top_in, res_ff, res_in;
   logic init_ff, init_in;
   logic [A-1:0] free_start_ff [FREE_ENTRIES], free_start_in [FREE_ENTRIES];
   logic [A-1:0] free_end_ff [FREE_ENTRIES], free_end_in [FREE_ENTRIES];
   logic free_valid_ff [FREE_ENTRIES], free_valid_in [FREE_ENTRIES];
   logic [ID_BITS-1:0] used_owner_ff [USED_ENTRIES], used_owner_in [USED_ENTRIES];
   logic [A-1:0] used_start_ff [USED_ENTRIES], used_start_in [USED_ENTRIES];
   logic [A-1:0] used_end_ff [USED_ENTRIES], used_end_in [USED_ENTRIES];
   logic used_valid_ff [USED_ENTRIES], used_valid_in [USED_ENTRIES];
   logic moved_ff [USED_ENTRIES], moved_in [USED_ENTRIES];
   logic [S-1:0] used_total_ff, used_total_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   req_type req_ff, req_in;
   logic [USED_IDX_BITS-1:0] slot_ff, slot_in;
   logic slot_found_ff, slot_found_in;
   logic [FREE_IDX_BITS-1:0] best_ff, best_in;
   logic [S-1:0] best_sz_ff, best_sz_in;
   logic [A-1:0] best_start_ff, best_start_in;
   logic fit_found_ff, fit_found_in;
   logic compacted_ff, compacted_in;
   logic [USED_IDX_BITS-1:0] pick_ff, pick_in;
   logic [A-1:0] pick_start_ff, pick_start_in;
   logic [S-1:0] pick_sz_ff, pick_sz_in;
   logic pick_found_ff, pick_found_in;
   logic [S-1:0] cursor_ff, cursor_in;
   logic [USED_IDX_BITS-1:0] own_ff, own_in;
   logic [A-1:0] rel_s_ff, rel_s_in, rel_e_ff, rel_e_in;
   logic owner_found_ff, owner_found_in;
   logic [FREE_IDX_BITS-1:0] above_ff, above_in, below_ff, below_in, spare_ff, spare_in;
   logic above_found_ff, above_found_in, below_found_ff, below_found_in;
   logic spare_found_ff, spare_found_in;
   logic [A-1:0] above_end_ff, above_end_in, below_start_ff, below_start_in;
   status_type res_status_ff, res_status_in;
   logic [A-1:0] res_base_ff, res_base_in;
   logic [S-1:0] res_size_ff, res_size_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [FREE_IDX_BITS-1:0] idx_f;
   logic [USED_IDX_BITS-1:0] idx_u;
   logic [A-1:0] rd_fs, rd_fe, rd_us, rd_ue;
   logic rd_fv, rd_uv, rd_mv;
   logic [ID_BITS-1:0] rd_uo;
   logic [S-1:0] rd_fsz, rd_usz, total, free_amt, rel_sz;
   logic free_scan, used_scan, last, do_init;
   logic [FREE_IDX_BITS-1:0] dst;

   assign idx_f = idx_ff[FREE_IDX_BITS-1:0];
   assign idx_u = idx_ff[USED_IDX_BITS-1:0];
   assign rd_fs = free_start_ff[idx_f];
   assign rd_fe = free_end_ff[idx_f];
   assign rd_fv = free_valid_ff[idx_f];
   assign rd_us = used_start_ff[idx_u];
   assign rd_ue = used_end_ff[idx_u];
   assign rd_uo = used_owner_ff[idx_u];
   assign rd_uv = used_valid_ff[idx_u];
   assign rd_mv = moved_ff[idx_u];
   assign rd_fsz = {1'b0, rd_fe} - {1'b0, rd_fs} + S'(1);
   assign rd_usz = {1'b0, rd_ue} - {1'b0, rd_us} + S'(1);
   assign total = {1'b0, top_ff} + S'(1);
   assign free_amt = (used_total_ff >= total) ? S'(0) : total - used_total_ff;
   assign rel_sz = {1'b0, rel_e_ff} - {1'b0, rel_s_ff} + S'(1);

   assign free_scan = (cmd.op == DP_FIT) || (cmd.op == DP_MERGE);
   assign used_scan = (cmd.op == DP_SLOT) || (cmd.op == DP_CPICK) || (cmd.op == DP_FIND);
   assign last = (free_scan && (idx_ff == IDX_BITS'(FREE_ENTRIES - 1)))
              || (used_scan && (idx_ff == IDX_BITS'(USED_ENTRIES - 1)));
   assign do_init = init_ff
                 || (csr_we && ((csr_index == CSR_MEMORY_TOP) || (csr_index == CSR_RESERVED_SIZE)));

   always_comb begin
      top_in = top_ff;
      res_in = res_ff;
      init_in = 1'b0;
      free_start_in = free_start_ff;
      free_end_in = free_end_ff;
      free_valid_in = free_valid_ff;
      used_owner_in = used_owner_ff;
      used_start_in = used_start_ff;
      used_end_in = used_end_ff;
      used_valid_in = used_valid_ff;
      moved_in = moved_ff;
      used_total_in = used_total_ff;
      idx_in = ((free_scan || used_scan) && !last) ? idx_ff + IDX_BITS'(1) : '0;
      req_in = req_ff;
      slot_in = slot_ff;
      slot_found_in = slot_found_ff;
      best_in = best_ff;
      best_sz_in = best_sz_ff;
      best_start_in = best_start_ff;
      fit_found_in = fit_found_ff;
      compacted_in = compacted_ff;
      pick_in = pick_ff;
      pick_start_in = pick_start_ff;
      pick_sz_in = pick_sz_ff;
      pick_found_in = pick_found_ff;
      cursor_in = cursor_ff;
      own_in = own_ff;
      rel_s_in = rel_s_ff;
      rel_e_in = rel_e_ff;
      owner_found_in = owner_found_ff;
      above_in = above_ff;
      below_in = below_ff;
      spare_in = spare_ff;
      above_found_in = above_found_ff;
      below_found_in = below_found_ff;
      spare_found_in = spare_found_ff;
      above_end_in = above_end_ff;
      below_start_in = below_start_ff;
      res_status_in = res_status_ff;
      res_base_in = res_base_ff;
      res_size_in = res_size_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dst = below_found_ff ? below_ff : (above_found_ff ? above_ff : spare_ff);

      case (cmd.op)
         DP_START: begin
            req_in = req_data;
            slot_found_in = 1'b0;
            fit_found_in = 1'b0;
            pick_found_in = 1'b0;
            owner_found_in = 1'b0;
            above_found_in = 1'b0;
            below_found_in = 1'b0;
            spare_found_in = 1'b0;
            compacted_in = 1'b0;
            cursor_in = {1'b0, res_ff};
            for (int i = 0; i < USED_ENTRIES; i++) moved_in[i] = 1'b0;
         end
         DP_SLOT: begin
            if (!rd_uv && !slot_found_ff) begin
               slot_in = idx_u;
               slot_found_in = 1'b1;
            end
         end
         DP_FIT: begin
            if (rd_fv && (rd_fsz >= req_ff.request_size) && (!fit_found_ff
                || (rd_fsz < best_sz_ff) || ((rd_fsz == best_sz_ff) && (rd_fs < best_start_ff)))) begin
               best_in = idx_f;
               best_sz_in = rd_fsz;
               best_start_in = rd_fs;
               fit_found_in = 1'b1;
            end
         end
         DP_CPICK: begin
            if (rd_uv && !rd_mv && (!pick_found_ff || (rd_us < pick_start_ff))) begin
               pick_in = idx_u;
               pick_start_in = rd_us;
               pick_sz_in = rd_usz;
               pick_found_in = 1'b1;
            end
         end
         DP_CMOVE: begin
            // place the lowest unmoved region at the packing cursor
            if (pick_found_ff) begin
               used_start_in[pick_ff] = cursor_ff[A-1:0];
               used_end_in[pick_ff] = A'(cursor_ff + pick_sz_ff - S'(1));
               moved_in[pick_ff] = 1'b1;
               cursor_in = cursor_ff + pick_sz_ff;
            end
            pick_found_in = 1'b0;
         end
         DP_CFREE: begin
            for (int i = 0; i < FREE_ENTRIES; i++) free_valid_in[i] = 1'b0;
            free_start_in[0] = cursor_ff[A-1:0];
            free_end_in[0] = top_ff;
            free_valid_in[0] = 1'b1;
            best_in = '0;
            best_sz_in = {1'b0, top_ff} - cursor_ff + S'(1);
            best_start_in = cursor_ff[A-1:0];
            compacted_in = 1'b1;
         end
         DP_ALLOC: begin
            used_owner_in[slot_ff] = req_ff.job_id;
            used_start_in[slot_ff] = best_start_ff;
            used_end_in[slot_ff] = A'({1'b0, best_start_ff} + req_ff.request_size - S'(1));
            used_valid_in[slot_ff] = 1'b1;
            used_total_in = used_total_ff + req_ff.request_size;
            if (best_sz_ff == req_ff.request_size) free_valid_in[best_ff] = 1'b0;
            else free_start_in[best_ff] = A'({1'b0, best_start_ff} + req_ff.request_size);
            res_status_in = compacted_ff ? ST_COMPACTED : ST_BEST_FIT;
            res_base_in = best_start_ff;
            res_size_in = req_ff.request_size;
         end
         DP_FIND: begin
            if (!owner_found_ff && rd_uv && (rd_uo == req_ff.job_id)) begin
               own_in = idx_u;
               rel_s_in = rd_us;
               rel_e_in = rd_ue;
               owner_found_in = 1'b1;
            end
         end
         DP_MERGE: begin
            if (!rd_fv) begin
               if (!spare_found_ff) begin
                  spare_in = idx_f;
                  spare_found_in = 1'b1;
               end
            end else begin
               if (!above_found_ff && ({1'b0, rd_fs} == {1'b0, rel_e_ff} + S'(1))) begin
                  above_in = idx_f;
                  above_end_in = rd_fe;
                  above_found_in = 1'b1;
               end
               if (!below_found_ff && ({1'b0, rd_fe} + S'(1) == {1'b0, rel_s_ff})) begin
                  below_in = idx_f;
                  below_start_in = rd_fs;
                  below_found_in = 1'b1;
               end
            end
         end
         DP_REL: begin
            if (above_found_ff) free_valid_in[above_ff] = 1'b0;
            if (below_found_ff) free_valid_in[below_ff] = 1'b0;
            free_start_in[dst] = below_found_ff ? below_start_ff : rel_s_ff;
            free_end_in[dst] = above_found_ff ? above_end_ff : rel_e_ff;
            free_valid_in[dst] = 1'b1;
            used_valid_in[own_ff] = 1'b0;
            used_total_in = (used_total_ff >= rel_sz) ? used_total_ff - rel_sz : S'(0);
            res_status_in = ST_RELEASED;
            res_base_in = rel_s_ff;
            res_size_in = rel_sz;
         end
         DP_REJ_SIZE: begin
            res_status_in = ST_INSUFFICIENT;
            res_base_in = '0;
            res_size_in = req_ff.request_size;
         end
         DP_REJ_FULL: begin
            res_status_in = ST_TABLE_FULL;
            res_base_in = '0;
            res_size_in = (req_ff.op == OP_RELEASE) ? S'(0) : req_ff.request_size;
         end
         DP_REJ_ID: begin
            res_status_in = ST_ID_NOT_FOUND;
            res_base_in = '0;
            res_size_in = '0;
         end
         DP_LOAD: begin
            rsp_in.status = res_status_ff;
            rsp_in.job_id_out = req_ff.job_id;
            rsp_in.base_address = res_base_ff;
            rsp_in.region_size = res_size_ff;
            rsp_in.free_total = free_amt;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase

      // register write or reset: rebuild both tables from the new bounds
      if (csr_we && (csr_index == CSR_MEMORY_TOP)) top_in = csr_wdata;
      if (csr_we && (csr_index == CSR_RESERVED_SIZE)) res_in = csr_wdata;
      if (do_init) begin
         for (int i = 0; i < FREE_ENTRIES; i++) free_valid_in[i] = 1'b0;
         for (int i = 0; i < USED_ENTRIES; i++) used_valid_in[i] = 1'b0;
         free_start_in[0] = res_in;
         free_end_in[0] = top_in;
         free_valid_in[0] = (res_in <= top_in);
         used_total_in = {1'b0, res_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff <= MEM_TOP_RESET;
         res_ff <= RESERVED_RESET;
         init_ff <= 1'b1;
         free_valid_ff <= '{default: 1'b0};
         used_valid_ff <= '{default: 1'b0};
         rsp_valid_ff <= 1'b0;
      end else begin
         top_ff <= top_in;
         res_ff <= res_in;
         init_ff <= init_in;
         free_valid_ff <= free_valid_in;
         used_valid_ff <= used_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      free_start_ff <= free_start_in;
      free_end_ff <= free_end_in;
      used_owner_ff <= used_owner_in;
      used_start_ff <= used_start_in;
      used_end_ff <= used_end_in;
      moved_ff <= moved_in;
      used_total_ff <= used_total_in;
      idx_ff <= idx_in;
      req_ff <= req_in;
      slot_ff <= slot_in;
      slot_found_ff <= slot_found_in;
      best_ff <= best_in;
      best_sz_ff <= best_sz_in;
      best_start_ff <= best_start_in;
      fit_found_ff <= fit_found_in;
      compacted_ff <= compacted_in;
      pick_ff <= pick_in;
      pick_start_ff <= pick_start_in;
      pick_sz_ff <= pick_sz_in;
      pick_found_ff <= pick_found_in;
      cursor_ff <= cursor_in;
      own_ff <= own_in;
      rel_s_ff <= rel_s_in;
      rel_e_ff <= rel_e_in;
      owner_found_ff <= owner_found_in;
      above_ff <= above_in;
      below_ff <= below_in;
      spare_ff <= spare_in;
      above_found_ff <= above_found_in;
      below_found_ff <= below_found_in;
      spare_found_ff <= spare_found_in;
      above_end_ff <= above_end_in;
      below_start_ff <= below_start_in;
      res_status_ff <= res_status_in;
      res_base_ff <= res_base_in;
      res_size_ff <= res_size_in;
      rsp_ff <= rsp_in;
   end

   assign st.last = last;
   assign st.init_busy = init_ff;
   assign st.alloc_reject = (req_ff.request_size == S'(0)) || (req_ff.request_size > free_amt);
   assign st.slot_found = slot_found_ff;
   assign st.fit_found = fit_found_ff;
   assign st.pick_found = pick_found_ff;
   assign st.owner_found = owner_found_ff;
   assign st.merge_ok = above_found_ff || below_found_ff || spare_found_ff;
   assign st.rsp_full = rsp_valid_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ===== rtl/core/bfpa_checker.sv =====
// port-level checks of the allocator, bound to the top level
`include "best_fit_partition_allocator_assert.svh"

module bfpa_checker
   import bfpa_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input req_type req_data,
   input logic rsp_valid,
   input logic rsp_ready,
   input rsp_type rsp_data
);

   `BFPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result dropped or changed while stalled")

   // one request at a time: a new transaction is never taken back to back
   `BFPA_ASSERT_NXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "request taken while busy")

   `BFPA_ASSERT_IMP(a_reject_base, clock, reset, rsp_valid && (rsp_data.status == ST_INSUFFICIENT || rsp_data.status == ST_ID_NOT_FOUND || rsp_data.status == ST_TABLE_FULL), rsp_data.base_address == '0, "rejected transaction carries a base address")

   `BFPA_ASSERT_IMP(a_release_size, clock, reset, rsp_valid && rsp_data.status == ST_RELEASED, rsp_data.region_size != '0, "released region has no size")

endmodule

bind best_fit_partition_allocator bfpa_checker u_bfpa_checker (.*);
